[rtl/core/abmd_pkg.sv]
`default_nettype none

package abmd_pkg;

   localparam int SMP_W       = 12;
   localparam int SUM_W       = 18;
   localparam int CNT_W       = 7;
   localparam int MEAN_W      = 12;
   localparam int THR_W       = 12;
   localparam int RECIP_SHIFT = 25;
   localparam int RECIP_W     = 26;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);

   typedef enum logic {
      KIND_BASELINE = 1'b0,
      KIND_WINDOW   = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [SUM_W-1:0]   sum_x;
      logic [SUM_W-1:0]   sum_y;
      logic [SUM_W-1:0]   sum_z;
   } win_beat_type;

   typedef struct packed {
      kind_type           kind;
      logic [MEAN_W-1:0]  mean_x;
      logic [MEAN_W-1:0]  mean_y;
      logic [MEAN_W-1:0]  mean_z;
   } mean_beat_type;

   typedef struct packed {
      kind_type           result_kind;
      logic               moved;
      logic [MEAN_W-1:0]  delta_x;
      logic [MEAN_W-1:0]  delta_y;
      logic [MEAN_W-1:0]  delta_z;
   } rsp_beat_type;

endpackage

`default_nettype wire

[rtl/core/abmd_req_if.sv]
`default_nettype none

interface abmd_req_if;
   import abmd_pkg::*;

   logic              valid;
   logic              ready;
   logic [SMP_W-1:0]  x_sample;
   logic [SMP_W-1:0]  y_sample;
   logic [SMP_W-1:0]  z_sample;

   modport source (output valid, output x_sample, output y_sample, output z_sample,
                   input ready);
   modport sink   (input valid, input x_sample, input y_sample, input z_sample,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/abmd_rsp_if.sv]
`default_nettype none

interface abmd_rsp_if;
   import abmd_pkg::*;

   logic               valid;
   logic               ready;
   logic               result_kind;
   logic               moved;
   logic [MEAN_W-1:0]  delta_x;
   logic [MEAN_W-1:0]  delta_y;
   logic [MEAN_W-1:0]  delta_z;

   modport source (output valid, output result_kind, output moved,
                   output delta_x, output delta_y, output delta_z, input ready);
   modport sink   (input valid, input result_kind, input moved,
                   input delta_x, input delta_y, input delta_z, output ready);
endinterface

`default_nettype wire

[rtl/core/abmd_accum.sv]
`default_nettype none

module abmd_accum #(
   parameter int WINDOW_SIZE   = 16,
   parameter int BASELINE_SIZE = 32,
   parameter int SAMPLE_BITS   = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   abmd_req_if.sink                   req_if,
   output logic                       win_valid_o,
   output abmd_pkg::win_beat_type     win_beat_o,
   input  wire logic                  win_ready_i
);
   import abmd_pkg::*;

   localparam int MASK_BITS = (SAMPLE_BITS < SMP_W) ? SAMPLE_BITS : SMP_W;
   localparam logic [SMP_W-1:0] SAMPLE_MASK = SMP_W'((64'd1 << MASK_BITS) - 64'd1);
   localparam logic [CNT_W-1:0] WIN_SPAN  = CNT_W'(WINDOW_SIZE);
   localparam logic [CNT_W-1:0] BASE_SPAN = CNT_W'(BASELINE_SIZE);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_x_ff, sum_x_in;
   logic [SUM_W-1:0]  sum_y_ff, sum_y_in;
   logic [SUM_W-1:0]  sum_z_ff, sum_z_in;
   logic              baseline_ready_ff, baseline_ready_in;
   logic              win_valid_ff, win_valid_in;
   win_beat_type      win_beat_ff, win_beat_in;

   logic              take;
   logic              last;
   logic [CNT_W-1:0]  span;
   logic [CNT_W-1:0]  count_next;
   logic [SUM_W-1:0]  sum_x_next, sum_y_next, sum_z_next;

   assign req_if.ready = !win_valid_ff || win_ready_i;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      span       = baseline_ready_ff ? WIN_SPAN : BASE_SPAN;
      count_next = CNT_W'(count_ff + 1'b1);
      last       = (count_next == span);
      sum_x_next = SUM_W'(sum_x_ff + SUM_W'(req_if.x_sample & SAMPLE_MASK));
      sum_y_next = SUM_W'(sum_y_ff + SUM_W'(req_if.y_sample & SAMPLE_MASK));
      sum_z_next = SUM_W'(sum_z_ff + SUM_W'(req_if.z_sample & SAMPLE_MASK));

      count_in          = count_ff;
      sum_x_in          = sum_x_ff;
      sum_y_in          = sum_y_ff;
      sum_z_in          = sum_z_ff;
      baseline_ready_in = baseline_ready_ff;
      win_valid_in      = win_valid_ff && !win_ready_i;
      win_beat_in       = win_beat_ff;

      if (take) begin
         if (last) begin
            count_in          = '0;
            sum_x_in          = '0;
            sum_y_in          = '0;
            sum_z_in          = '0;
            baseline_ready_in = 1'b1;
            win_valid_in      = 1'b1;
            win_beat_in.kind  = baseline_ready_ff ? KIND_WINDOW : KIND_BASELINE;
            win_beat_in.sum_x = sum_x_next;
            win_beat_in.sum_y = sum_y_next;
            win_beat_in.sum_z = sum_z_next;
         end else begin
            count_in = count_next;
            sum_x_in = sum_x_next;
            sum_y_in = sum_y_next;
            sum_z_in = sum_z_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff          <= '0;
         sum_x_ff          <= '0;
         sum_y_ff          <= '0;
         sum_z_ff          <= '0;
         baseline_ready_ff <= 1'b0;
         win_valid_ff      <= 1'b0;
      end else begin
         count_ff          <= count_in;
         sum_x_ff          <= sum_x_in;
         sum_y_ff          <= sum_y_in;
         sum_z_ff          <= sum_z_in;
         baseline_ready_ff <= baseline_ready_in;
         win_valid_ff      <= win_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_beat_ff <= win_beat_in;
   end

   assign win_valid_o = win_valid_ff;
   assign win_beat_o  = win_beat_ff;

   // count stays below the active span
   assert property (@(posedge clock) disable iff (reset) count_ff < span)
      else $error("sample count reached window span");

   // a completed span restarts the count and marks the baseline taken
   assert property (@(posedge clock) disable iff (reset)
      take && last |=> count_ff == '0 && baseline_ready_ff && win_valid_ff)
      else $error("span completion not recorded");

   // only the first completed span is a baseline beat
   assert property (@(posedge clock) disable iff (reset)
      take && last && baseline_ready_ff |=> win_beat_ff.kind == KIND_WINDOW)
      else $error("baseline beat issued twice");

endmodule

`default_nettype wire

[rtl/core/abmd_mean.sv]
`default_nettype none

module abmd_mean #(
   parameter int WINDOW_SIZE   = 16,
   parameter int BASELINE_SIZE = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  win_valid_i,
   input  abmd_pkg::win_beat_type     win_beat_i,
   output logic                       win_ready_o,
   output logic                       mean_valid_o,
   output abmd_pkg::mean_beat_type    mean_beat_o,
   input  wire logic                  mean_ready_i
);
   import abmd_pkg::*;

   localparam int PROD_W = SUM_W + RECIP_W;
   // exact for every 18 bit sum since the span fits the 7 bit count, so is at most 127
   localparam logic [RECIP_W-1:0] WIN_RECIP = RECIP_W'(
      ((longint'(1) << RECIP_SHIFT) + longint'(WINDOW_SIZE) - 1) / longint'(WINDOW_SIZE));
   localparam logic [RECIP_W-1:0] BASE_RECIP = RECIP_W'(
      ((longint'(1) << RECIP_SHIFT) + longint'(BASELINE_SIZE) - 1) / longint'(BASELINE_SIZE));

   logic              mean_valid_ff, mean_valid_in;
   mean_beat_type     mean_beat_ff, mean_beat_in;

   logic              take;
   logic [RECIP_W-1:0] recip;
   logic [PROD_W-1:0] prod_x, prod_y, prod_z;

   assign win_ready_o = !mean_valid_ff || mean_ready_i;
   assign take        = win_valid_i && win_ready_o;

   always_comb begin
      recip  = (win_beat_i.kind == KIND_WINDOW) ? WIN_RECIP : BASE_RECIP;
      prod_x = PROD_W'(win_beat_i.sum_x) * PROD_W'(recip);
      prod_y = PROD_W'(win_beat_i.sum_y) * PROD_W'(recip);
      prod_z = PROD_W'(win_beat_i.sum_z) * PROD_W'(recip);

      mean_valid_in = mean_valid_ff && !mean_ready_i;
      mean_beat_in  = mean_beat_ff;
      if (take) begin
         mean_valid_in       = 1'b1;
         mean_beat_in.kind   = win_beat_i.kind;
         mean_beat_in.mean_x = prod_x[RECIP_SHIFT +: MEAN_W];
         mean_beat_in.mean_y = prod_y[RECIP_SHIFT +: MEAN_W];
         mean_beat_in.mean_z = prod_z[RECIP_SHIFT +: MEAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_valid_ff <= 1'b0;
      end else begin
         mean_valid_ff <= mean_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_beat_ff <= mean_beat_in;
   end

   assign mean_valid_o = mean_valid_ff;
   assign mean_beat_o  = mean_beat_ff;

endmodule

`default_nettype wire

[rtl/core/abmd_judge.sv]
`default_nettype none

module abmd_judge (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       mean_valid_i,
   input  abmd_pkg::mean_beat_type         mean_beat_i,
   output logic                            mean_ready_o,
   input  wire logic [abmd_pkg::THR_W-1:0] threshold_i,
   abmd_rsp_if.source                      rsp_if
);
   import abmd_pkg::*;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_beat_type       rsp_beat_ff, rsp_beat_in;
   logic [MEAN_W-1:0]  base_x_ff, base_x_in;
   logic [MEAN_W-1:0]  base_y_ff, base_y_in;
   logic [MEAN_W-1:0]  base_z_ff, base_z_in;

   logic               take;
   logic [MEAN_W-1:0]  dx, dy, dz;

   assign mean_ready_o = !rsp_valid_ff || rsp_if.ready;
   assign take         = mean_valid_i && mean_ready_o;

   always_comb begin
      dx = (mean_beat_i.mean_x > base_x_ff) ? mean_beat_i.mean_x - base_x_ff
                                            : base_x_ff - mean_beat_i.mean_x;
      dy = (mean_beat_i.mean_y > base_y_ff) ? mean_beat_i.mean_y - base_y_ff
                                            : base_y_ff - mean_beat_i.mean_y;
      dz = (mean_beat_i.mean_z > base_z_ff) ? mean_beat_i.mean_z - base_z_ff
                                            : base_z_ff - mean_beat_i.mean_z;

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_beat_in  = rsp_beat_ff;
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      base_z_in    = base_z_ff;

      if (take) begin
         rsp_valid_in            = 1'b1;
         rsp_beat_in.result_kind = mean_beat_i.kind;
         if (mean_beat_i.kind == KIND_BASELINE) begin
            base_x_in           = mean_beat_i.mean_x;
            base_y_in           = mean_beat_i.mean_y;
            base_z_in           = mean_beat_i.mean_z;
            rsp_beat_in.moved   = 1'b0;
            rsp_beat_in.delta_x = '0;
            rsp_beat_in.delta_y = '0;
            rsp_beat_in.delta_z = '0;
         end else begin
            rsp_beat_in.moved   = (dx > threshold_i) || (dy > threshold_i)
                                  || (dz > threshold_i);
            rsp_beat_in.delta_x = dx;
            rsp_beat_in.delta_y = dy;
            rsp_beat_in.delta_z = dz;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
      base_x_ff   <= base_x_in;
      base_y_ff   <= base_y_in;
      base_z_ff   <= base_z_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_kind = logic'(rsp_beat_ff.result_kind);
   assign rsp_if.moved       = rsp_beat_ff.moved;
   assign rsp_if.delta_x     = rsp_beat_ff.delta_x;
   assign rsp_if.delta_y     = rsp_beat_ff.delta_y;
   assign rsp_if.delta_z     = rsp_beat_ff.delta_z;

   // baseline beat carries no deviation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_beat_ff.result_kind == KIND_BASELINE |->
         !rsp_beat_ff.moved && rsp_beat_ff.delta_x == '0
         && rsp_beat_ff.delta_y == '0 && rsp_beat_ff.delta_z == '0)
      else $error("baseline beat with nonzero deviation");

   // a baseline beat loads the stored baseline (x and z are checked)
   assert property (@(posedge clock) disable iff (reset)
      take && mean_beat_i.kind == KIND_BASELINE |=>
         base_x_ff == $past(mean_beat_i.mean_x) && base_z_ff == $past(mean_beat_i.mean_z))
      else $error("baseline not captured");

endmodule

`default_nettype wire

[rtl/core/accel_baseline_motion_detect.sv]
// a sample that completes a window or the baseline shows its result
//   on rsp once it has passed the sums, mean and result registers in turn
// throughput: one sample per cycle while rsp is ready; a stall on rsp backs up through the three registers
// reset: sums, sample count and baseline flag clear; motion threshold returns to 100
// the baseline is captured from the first BASELINE_SIZE samples after reset
`default_nettype none

module accel_baseline_motion_detect #(
   parameter int WINDOW_SIZE   = 16,
   parameter int BASELINE_SIZE = 32,
   parameter int SAMPLE_BITS   = 12
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [abmd_pkg::THR_W-1:0] csr_wdata,
   abmd_req_if.sink                        req_if,
   abmd_rsp_if.source                      rsp_if
);
   import abmd_pkg::*;

   logic [THR_W-1:0]  threshold_ff, threshold_in;

   logic              win_valid;
   win_beat_type      win_beat;
   logic              win_ready;
   logic              mean_valid;
   mean_beat_type     mean_beat;
   logic              mean_ready;

   assign threshold_in = csr_we ? csr_wdata : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   abmd_accum #(
      .WINDOW_SIZE   (WINDOW_SIZE),
      .BASELINE_SIZE (BASELINE_SIZE),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .win_valid_o (win_valid),
      .win_beat_o  (win_beat),
      .win_ready_i (win_ready)
   );

   abmd_mean #(
      .WINDOW_SIZE   (WINDOW_SIZE),
      .BASELINE_SIZE (BASELINE_SIZE)
   ) u_mean (
      .clock        (clock),
      .reset        (reset),
      .win_valid_i  (win_valid),
      .win_beat_i   (win_beat),
      .win_ready_o  (win_ready),
      .mean_valid_o (mean_valid),
      .mean_beat_o  (mean_beat),
      .mean_ready_i (mean_ready)
   );

   abmd_judge u_judge (
      .clock        (clock),
      .reset        (reset),
      .mean_valid_i (mean_valid),
      .mean_beat_i  (mean_beat),
      .mean_ready_o (mean_ready),
      .threshold_i  (threshold_ff),
      .rsp_if       (rsp_if)
   );

endmodule

`default_nettype wire
